FILE: design/ted_pkg.sv
// package: types, codes and helper functions for the tag event detector
`timescale 1ns / 1ps
`default_nettype none
package ted_pkg;

	localparam int MAX_ELEMENTS_DEF = 256;
	localparam int VALUE_W = 64;
	localparam int WORD_W = VALUE_W + 1;

	typedef enum logic [2:0] {
		EV_WRITE    = 3'd0,
		EV_CHANGE   = 3'd1,
		EV_SET      = 3'd2,
		EV_RESET    = 3'd3,
		EV_EQUAL    = 3'd4,
		EV_GREATER  = 3'd5,
		EV_LESS     = 3'd6,
		EV_DEADBAND = 3'd7
	} event_kind_t;

	localparam logic [3:0] TYPE_BOOL = 4'd0;
	localparam logic [3:0] TYPE_U8   = 4'd1;
	localparam logic [3:0] TYPE_S8   = 4'd2;
	localparam logic [3:0] TYPE_U16  = 4'd3;
	localparam logic [3:0] TYPE_S16  = 4'd4;
	localparam logic [3:0] TYPE_U32  = 4'd5;
	localparam logic [3:0] TYPE_S32  = 4'd6;
	localparam logic [3:0] TYPE_U64  = 4'd7;
	localparam logic [3:0] TYPE_S64  = 4'd8;

	localparam logic [2:0] CFG_EVENT_KIND    = 3'd0;
	localparam logic [2:0] CFG_ELEMENT_TYPE  = 3'd1;
	localparam logic [2:0] CFG_FIRST_ELEMENT = 3'd2;
	localparam logic [2:0] CFG_ELEMENT_COUNT = 3'd3;
	localparam logic [2:0] CFG_THRESHOLD     = 3'd4;

	localparam logic KIND_ELEMENT  = 1'b0;
	localparam logic KIND_BASELINE = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [7:0]         element_index;
		logic [VALUE_W-1:0] value;
		logic               last_in_write;
	} item_t;

	typedef struct packed {
		logic element_hit;
		logic write_fires;
	} result_t;

	typedef struct packed {
		event_kind_t        event_kind;
		logic [3:0]         element_type;
		logic [7:0]         first_element;
		logic [8:0]         element_count;
		logic [VALUE_W-1:0] threshold;
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic              wr_en;
		logic [WORD_W-1:0] wr_word;
	} eval_t;

	function automatic logic type_signed(input logic [3:0] ty);
		return ty inside {TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64};
	endfunction

	function automatic logic [VALUE_W-1:0] type_mask(input logic [3:0] ty);
		logic [VALUE_W-1:0] m;
		case (ty)
			TYPE_BOOL: m = 64'h1;
			TYPE_U8, TYPE_S8: m = 64'hFF;
			TYPE_U16, TYPE_S16: m = 64'hFFFF;
			TYPE_U32, TYPE_S32: m = 64'hFFFF_FFFF;
			default: m = '1;
		endcase
		return m;
	endfunction

	// low bits at the type width, sign extended for signed types
	function automatic logic [VALUE_W-1:0] ext_value(input logic [VALUE_W-1:0] v,
			input logic [3:0] ty);
		logic [VALUE_W-1:0] r;
		case (ty)
			TYPE_BOOL: r = {63'd0, v[0]};
			TYPE_U8: r = {56'd0, v[7:0]};
			TYPE_S8: r = {{56{v[7]}}, v[7:0]};
			TYPE_U16: r = {48'd0, v[15:0]};
			TYPE_S16: r = {{48{v[15]}}, v[15:0]};
			TYPE_U32: r = {32'd0, v[31:0]};
			TYPE_S32: r = {{32{v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/ted_eval.sv
// event condition evaluation and write-back word for one element
`timescale 1ns / 1ps
`default_nettype none
module ted_eval
	import ted_pkg::*;
(
	input  wire cfg_t                cfg,
	input  wire logic                kind,
	input  wire logic                in_window,
	input  wire logic [VALUE_W-1:0]  a,
	input  wire logic [WORD_W-1:0]   old_word,
	input  wire logic                lat_old,
	output eval_t                    ev
);

	logic               sgn;
	logic               is_bool;
	logic               active;
	logic [VALUE_W-1:0] sign_flip;
	logic [VALUE_W-1:0] v;
	logic [VALUE_W-1:0] t;
	logic [VALUE_W-1:0] old_v;
	logic [VALUE_W-1:0] b;
	logic [VALUE_W-1:0] ka;
	logic [VALUE_W-1:0] kt;
	logic [VALUE_W-1:0] kb;
	logic [VALUE_W-1:0] d;
	logic               db_hit;
	logic               cond;
	logic               allowed;

	always_comb begin
		sgn = type_signed(cfg.element_type);
		is_bool = (cfg.element_type == TYPE_BOOL);
		active = in_window && (cfg.element_type <= TYPE_S64);
		sign_flip = {sgn, {(VALUE_W-1){1'b0}}};
		v = a & type_mask(cfg.element_type);
		t = ext_value(cfg.threshold, cfg.element_type);
		old_v = old_word[VALUE_W-1:0];
		b = ext_value(old_v, cfg.element_type);
		ka = a ^ sign_flip;
		kt = t ^ sign_flip;
		kb = b ^ sign_flip;
		d = (ka >= kb) ? (a - b) : (b - a);
		db_hit = (sgn && t[VALUE_W-1]) || (d >= t);
		cond = 1'b0;
		allowed = 1'b0;
		ev.hit = 1'b0;
		ev.wr_en = 1'b0;
		ev.wr_word = {lat_old, v};
		if (kind == KIND_BASELINE) begin
			ev.wr_en = active;
			ev.wr_word = {1'b0, v};
		end else begin
			case (cfg.event_kind)
				EV_WRITE: begin
					ev.hit = active;
				end
				EV_CHANGE: begin
					ev.hit = active && (v != old_v);
					ev.wr_en = ev.hit;
				end
				EV_DEADBAND: begin
					ev.hit = active && !is_bool && db_hit;
					ev.wr_en = ev.hit;
				end
				default: begin
					case (cfg.event_kind)
						EV_SET: begin
							allowed = is_bool;
							cond = (v != '0);
						end
						EV_RESET: begin
							allowed = is_bool;
							cond = (v == '0);
						end
						EV_EQUAL: begin
							allowed = !is_bool;
							cond = (a == t);
						end
						EV_GREATER: begin
							allowed = !is_bool;
							cond = (ka > kt);
						end
						EV_LESS: begin
							allowed = !is_bool;
							cond = (ka < kt);
						end
						default: begin
							allowed = 1'b0;
							cond = 1'b0;
						end
					endcase
					ev.wr_en = active && allowed;
					ev.hit = ev.wr_en && cond && !lat_old;
					ev.wr_word = {cond, old_v};
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/tag_event_detector_core.sv
// top level: window check, element state memory, read-modify-write pipeline
// an accepted item is registered in stage s1, then in the result register
// throughput: one item per cycle unless results stall, from one read and one write
// of the element memory per item, the last write forwarded to a same-entry read
// reset: clears configuration, per-element latch valid bits and the write hit flag;
// the last-value memory is not cleared and is read with no valid check
`timescale 1ns / 1ps
`default_nettype none
module tag_event_detector_core
	import ted_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [VALUE_W-1:0]  cfg_data,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire item_t               item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output result_t                  result
);

	localparam int DEPTH = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0] DEPTH_W = 9'(DEPTH);

	cfg_t cfg_q;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;

	logic              valid_s1;
	logic              kind_s1;
	logic              last_s1;
	logic              inside_s1;
	logic [AW-1:0]     rel_s1;
	logic [VALUE_W-1:0] a_s1;
	logic [WORD_W-1:0] rd_word_s1;

	logic              wr_seen_q;
	logic [AW-1:0]     wr_addr_q;
	logic [WORD_W-1:0] wr_word_q;

	logic              any_hit_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              accept;
	logic              s1_adv;
	logic              s1_fire;
	logic [7:0]        rel_in;
	logic              inside_in;
	logic [WORD_W-1:0] old_word;
	logic              lat_old;
	logic              do_write;
	logic              fires;
	eval_t             ev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.event_kind <= EV_WRITE;
			cfg_q.element_type <= TYPE_BOOL;
			cfg_q.first_element <= '0;
			cfg_q.element_count <= 9'd1;
			cfg_q.threshold <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EVENT_KIND: cfg_q.event_kind <= event_kind_t'(cfg_data[2:0]);
				CFG_ELEMENT_TYPE: cfg_q.element_type <= cfg_data[3:0];
				CFG_FIRST_ELEMENT: cfg_q.first_element <= cfg_data[7:0];
				CFG_ELEMENT_COUNT: cfg_q.element_count <= cfg_data[8:0];
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign s1_adv = !out_valid_q || !result_stall;
	assign s1_fire = valid_s1 && s1_adv;
	assign item_stall = valid_s1 && !s1_adv;
	assign accept = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result = out_q;

	// window check
	always_comb begin
		rel_in = item.element_index - cfg_q.first_element;
		inside_in = (item.element_index >= cfg_q.first_element)
			&& ({1'b0, rel_in} < cfg_q.element_count)
			&& ({1'b0, rel_in} < DEPTH_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= item.kind;
			last_s1 <= item.last_in_write;
			inside_s1 <= inside_in;
			rel_s1 <= rel_in[AW-1:0];
			a_s1 <= ext_value(item.value, cfg_q.element_type);
		end
	end

	// element memory
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_word_s1 <= mem[rel_in[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[rel_s1] <= ev.wr_word;
		end
	end

	// forward the most recent write
	always_comb begin
		old_word = (wr_seen_q && (wr_addr_q == rel_s1)) ? wr_word_q : rd_word_s1;
		lat_old = valid_q[rel_s1] && old_word[WORD_W-1];
	end

	ted_eval u_eval (
		.cfg       (cfg_q),
		.kind      (kind_s1),
		.in_window (inside_s1),
		.a         (a_s1),
		.old_word  (old_word),
		.lat_old   (lat_old),
		.ev        (ev)
	);

	assign do_write = s1_fire && ev.wr_en;
	assign fires = (kind_s1 == KIND_ELEMENT) && last_s1 && (any_hit_q || ev.hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			wr_seen_q <= 1'b0;
		end else if (do_write) begin
			valid_q[rel_s1] <= 1'b1;
			wr_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			wr_addr_q <= rel_s1;
			wr_word_q <= ev.wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_hit_q <= 1'b0;
		end else if (s1_fire && (kind_s1 == KIND_ELEMENT)) begin
			any_hit_q <= last_s1 ? 1'b0 : (any_hit_q || ev.hit);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q.element_hit <= ev.hit;
			out_q.write_fires <= fires;
		end
	end

endmodule
`default_nettype wire

FILE: sim/tag_event_detector_core_tb.sv
// testbench: random and directed event windows on the tag event detector, checked per beat
`timescale 1ns / 1ps
module tag_event_detector_core_tb;
	import ted_pkg::*;

	localparam int WINDOW_DEPTH = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = CFG_EVENT_KIND;
	logic [VALUE_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	tag_event_detector_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register shadow, written when a config beat completes
	event_kind_t cur_kind = EV_WRITE;
	logic [3:0] cur_type = TYPE_BOOL;
	logic [7:0] cur_first = '0;
	logic [8:0] cur_count = 9'd1;
	logic [63:0] cur_thr = '0;

	// per-element detector state
	bit [63:0] seen_value [WINDOW_DEPTH];
	bit cond_latched [WINDOW_DEPTH];
	bit write_hit_seen = 1'b0;

	// stimulus bookkeeping
	bit baseline_known [WINDOW_DEPTH];
	bit [63:0] recent_value [WINDOW_DEPTH];
	item_t item_q [$];
	result_t hits_due [$];
	result_t due_now;

	int failures = 0;
	int results_checked = 0;
	int hits_seen = 0;
	int fires_seen = 0;
	int items_queued = 0;
	int settings_run = 0;
	int burst_left = 0;
	int idle_left = 0;
	int cycle_no = 0;
	int stall_mode = 0;

	function automatic int unsigned width_of(logic [3:0] ty);
		case (ty)
			TYPE_BOOL: return 1;
			TYPE_U8, TYPE_S8: return 8;
			TYPE_U16, TYPE_S16: return 16;
			TYPE_U32, TYPE_S32: return 32;
			default: return 64;
		endcase
	endfunction

	function automatic logic [63:0] width_mask(logic [3:0] ty);
		int unsigned bits;
		bits = width_of(ty);
		return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
	endfunction

	function automatic bit is_signed_type(logic [3:0] ty);
		return ty == TYPE_S8 || ty == TYPE_S16 || ty == TYPE_S32 || ty == TYPE_S64;
	endfunction

	function automatic logic [63:0] widen(logic [63:0] v);
		int unsigned bits;
		bits = width_of(cur_type);
		if (is_signed_type(cur_type) && bits < 64 && v[bits-1])
			v = v | ~width_mask(cur_type);
		return v;
	endfunction

	function automatic logic [63:0] order_key(logic [63:0] v);
		return is_signed_type(cur_type) ? (v ^ {1'b1, 63'd0}) : v;
	endfunction

	// offset into the window, or -1 when the element is not watched
	function automatic int window_offset(logic [7:0] idx);
		int rel;
		rel = int'(idx) - int'(cur_first);
		if (rel >= 0 && rel < int'(cur_count) && rel < WINDOW_DEPTH)
			return rel;
		return -1;
	endfunction

	function automatic bit latch_rise(int rel, bit cond);
		if (!cond) begin
			cond_latched[rel] = 1'b0;
			return 1'b0;
		end
		if (cond_latched[rel])
			return 1'b0;
		cond_latched[rel] = 1'b1;
		return 1'b1;
	endfunction

	function automatic result_t evaluate_element(item_t it);
		result_t r;
		int rel;
		bit hit;
		bit is_bool;
		logic [63:0] v;
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] b;
		logic [63:0] d;
		r = '0;
		hit = 1'b0;
		rel = window_offset(it.element_index);
		if (it.kind == KIND_BASELINE) begin
			if (rel >= 0 && cur_type <= TYPE_S64) begin
				seen_value[rel] = it.value & width_mask(cur_type);
				cond_latched[rel] = 1'b0;
			end
			return r;
		end
		if (rel >= 0 && cur_type <= TYPE_S64) begin
			v = it.value & width_mask(cur_type);
			a = widen(v);
			t = widen(cur_thr & width_mask(cur_type));
			is_bool = cur_type == TYPE_BOOL;
			case (cur_kind)
				EV_WRITE: hit = 1'b1;
				EV_CHANGE: begin
					if (v != seen_value[rel]) begin
						seen_value[rel] = v;
						hit = 1'b1;
					end
				end
				EV_SET: if (is_bool) hit = latch_rise(rel, v != 0);
				EV_RESET: if (is_bool) hit = latch_rise(rel, v == 0);
				EV_EQUAL: if (!is_bool) hit = latch_rise(rel, a == t);
				EV_GREATER: if (!is_bool) hit = latch_rise(rel, order_key(a) > order_key(t));
				EV_LESS: if (!is_bool) hit = latch_rise(rel, order_key(a) < order_key(t));
				default: begin
					if (!is_bool) begin
						b = widen(seen_value[rel]);
						d = (order_key(a) >= order_key(b)) ? (a - b) : (b - a);
						hit = (is_signed_type(cur_type) && t[63]) || (d >= t);
						if (hit)
							seen_value[rel] = v;
					end
				end
			endcase
		end
		if (hit)
			write_hit_seen = 1'b1;
		r.element_hit = hit;
		if (it.last_in_write) begin
			r.write_fires = write_hit_seen;
			write_hit_seen = 1'b0;
		end
		return r;
	endfunction

	// sender: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				hits_due.push_back(evaluate_element(item));
			if (!item_valid || !item_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					item_valid <= 1'b0;
				end else if (item_q.size() > 0) begin
					item <= item_q.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each beat, stall in changing modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected beat hit=%0b fires=%0b", $time,
						result.element_hit, result.write_fires);
					failures++;
				end else begin
					due_now = hits_due.pop_front();
					results_checked++;
					hits_seen += result.element_hit;
					fires_seen += result.write_fires;
					if (result.element_hit !== due_now.element_hit) begin
						$display("%0t: element_hit expected %0b actual %0b", $time,
							due_now.element_hit, result.element_hit);
						failures++;
					end
					if (result.write_fires !== due_now.write_fires) begin
						$display("%0t: write_fires expected %0b actual %0b", $time,
							due_now.write_fires, result.write_fires);
						failures++;
					end
				end
			end
			cycle_no++;
			if (cycle_no % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= cycle_no[1];
			endcase
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (item_q.size() != 0 || item_valid || hits_due.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_EVENT_KIND: cur_kind = event_kind_t'(data[2:0]);
			CFG_ELEMENT_TYPE: cur_type = data[3:0];
			CFG_FIRST_ELEMENT: cur_first = data[7:0];
			CFG_ELEMENT_COUNT: cur_count = data[8:0];
			default: cur_thr = data;
		endcase
	endtask

	task automatic apply_settings(input event_kind_t kind, input logic [3:0] ty,
			input logic [7:0] first_el, input logic [8:0] count, input logic [63:0] thr);
		wait_idle();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ELEMENT_COUNT, {55'd0, count});
		write_reg(CFG_FIRST_ELEMENT, {56'd0, first_el});
		write_reg(CFG_ELEMENT_TYPE, {60'd0, ty});
		write_reg(CFG_EVENT_KIND, {61'd0, kind});
		settings_run++;
	endtask

	// a stored value is never compared before it has been loaded
	task automatic enqueue(input logic kind, input logic [7:0] idx, input logic [63:0] value,
			input logic last);
		int rel;
		item_t it;
		rel = window_offset(idx);
		if (rel >= 0 && cur_type <= TYPE_S64) begin
			if (kind == KIND_ELEMENT && !baseline_known[rel] &&
					(cur_kind == EV_CHANGE || cur_kind == EV_DEADBAND)) begin
				it.kind = KIND_BASELINE;
				it.element_index = idx;
				it.value = {$urandom, $urandom};
				it.last_in_write = $urandom_range(0, 1);
				item_q.push_back(it);
				items_queued++;
				baseline_known[rel] = 1'b1;
			end
			if (kind == KIND_BASELINE)
				baseline_known[rel] = 1'b1;
		end
		it.kind = kind;
		it.element_index = idx;
		it.value = value;
		it.last_in_write = last;
		item_q.push_back(it);
		items_queued++;
	endtask

	function automatic logic [63:0] pick_value(logic [7:0] idx);
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = {$urandom, $urandom};
			1: v = '0;
			2: v = '1;
			3, 4: v = cur_thr;
			5: v = cur_thr + 64'd1;
			6: v = cur_thr - 64'd1;
			7: v = recent_value[idx];
			8: v = recent_value[idx] + 64'($signed($urandom_range(0, 8)) - 4);
			default: v = $urandom_range(0, 3);
		endcase
		if ($urandom_range(0, 3) == 0)
			v = (v & width_mask(cur_type)) | ({$urandom, $urandom} & ~width_mask(cur_type));
		recent_value[idx] = v;
		return v;
	endfunction

	function automatic logic [63:0] pick_threshold(event_kind_t kind, logic [3:0] ty);
		logic [63:0] t;
		case ($urandom_range(0, 6))
			0: t = '0;
			1: t = '1;
			2: t = {$urandom, $urandom};
			3, 4: t = $urandom_range(0, 16);
			5: t = width_mask(ty) >> 1;
			default: t = (width_mask(ty) >> 1) + 64'd1;
		endcase
		if (kind == EV_DEADBAND && $urandom_range(0, 2) != 0)
			t = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0)
			t = (t & width_mask(ty)) | ({$urandom, $urandom} & ~width_mask(ty));
		return t;
	endfunction

	initial begin
		int round;
		int span;
		int len;
		int goal;
		event_kind_t kind;
		logic [3:0] ty;
		logic [7:0] first_el;
		logic [8:0] count;
		logic [7:0] idx;
		logic last;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, window edges, latch clearing, disallowed pairs
		apply_settings(EV_WRITE, TYPE_BOOL, 8'd0, 9'd1, 64'd0);
		enqueue(KIND_ELEMENT, 8'd0, '1, 1'b1);
		enqueue(KIND_ELEMENT, 8'd255, 64'd0, 1'b1);
		enqueue(KIND_BASELINE, 8'd0, 64'd1, 1'b1);
		apply_settings(EV_SET, TYPE_BOOL, 8'd250, 9'd256, '1);
		enqueue(KIND_ELEMENT, 8'd250, 64'd1, 1'b0);
		enqueue(KIND_ELEMENT, 8'd250, 64'd3, 1'b0);
		enqueue(KIND_ELEMENT, 8'd250, 64'd2, 1'b1);
		enqueue(KIND_ELEMENT, 8'd255, 64'd1, 1'b1);
		enqueue(KIND_BASELINE, 8'd255, 64'd1, 1'b0);
		enqueue(KIND_ELEMENT, 8'd255, 64'd1, 1'b1);
		enqueue(KIND_ELEMENT, 8'd249, 64'd1, 1'b1);
		apply_settings(EV_RESET, TYPE_U8, 8'd0, 9'd256, 64'd0);
		enqueue(KIND_ELEMENT, 8'd3, 64'd0, 1'b1);
		apply_settings(EV_DEADBAND, TYPE_S8, 8'd0, 9'd256, 64'h80);
		enqueue(KIND_BASELINE, 8'd7, 64'h7F, 1'b0);
		enqueue(KIND_ELEMENT, 8'd7, 64'h7F, 1'b1);
		apply_settings(EV_DEADBAND, TYPE_U32, 8'd0, 9'd256, 64'hFFFF_FFFF_0000_0010);
		enqueue(KIND_BASELINE, 8'd9, 64'd0, 1'b0);
		enqueue(KIND_ELEMENT, 8'd9, 64'hFFFF_FFF0, 1'b0);
		enqueue(KIND_ELEMENT, 8'd9, 64'hFFFF_FFE8, 1'b1);
		apply_settings(EV_GREATER, TYPE_S64, 8'd0, 9'd256, '1);
		enqueue(KIND_ELEMENT, 8'd4, 64'd0, 1'b0);
		enqueue(KIND_ELEMENT, 8'd4, 64'd5, 1'b0);
		enqueue(KIND_ELEMENT, 8'd4, {1'b1, 63'd0}, 1'b0);
		enqueue(KIND_ELEMENT, 8'd4, 64'd1, 1'b1);
		apply_settings(EV_WRITE, 4'd15, 8'd0, 9'd256, 64'd0);
		enqueue(KIND_ELEMENT, 8'd0, 64'd1, 1'b1);

		// random settings, each followed by tag writes mostly inside the window
		round = 0;
		while (items_queued < 1500) begin
			if (round < 16)
				kind = event_kind_t'(round % 8);
			else
				kind = event_kind_t'($urandom_range(0, 7));
			if (kind == EV_SET || kind == EV_RESET)
				ty = ($urandom_range(0, 9) < 7) ? TYPE_BOOL : 4'($urandom_range(0, 15));
			else if ($urandom_range(0, 99) < 8)
				ty = 4'($urandom_range(9, 15));
			else
				ty = 4'($urandom_range(0, 8));
			case ($urandom_range(0, 9))
				0, 1: first_el = 8'd0;
				2: first_el = 8'd255;
				default: first_el = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 9))
				0, 1: count = 9'd256;
				2: count = 9'd1;
				3, 4, 5, 6, 7: count = 9'($urandom_range(1, 16));
				default: count = 9'($urandom_range(1, 256));
			endcase
			apply_settings(kind, ty, first_el, count, pick_threshold(kind, ty));
			span = (int'(count) < 256 - int'(first_el)) ? int'(count) : 256 - int'(first_el);
			goal = items_queued + $urandom_range(30, 90);
			while (items_queued < goal) begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 9) < 8)
						idx = first_el + 8'($urandom_range(0, span - 1));
					else
						idx = 8'($urandom_range(0, 255));
					last = (j == len - 1);
					if ($urandom_range(0, 19) == 0)
						last = !last;
					if ($urandom_range(0, 99) < 8)
						enqueue(KIND_BASELINE, idx, pick_value(idx), $urandom_range(0, 1));
					else
						enqueue(KIND_ELEMENT, idx, pick_value(idx), last);
				end
			end
			round++;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("tb: %0d beats sent under %0d register settings", items_queued, settings_run);
		$display("tb: %0d results checked, %0d element hits, %0d write events",
			results_checked, hits_seen, fires_seen);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: tag_event_detector_core.f
design/ted_pkg.sv
design/ted_eval.sv
design/tag_event_detector_core.sv
sim/tag_event_detector_core_tb.sv
